>>> rtl/core/json_token_lexer_unit_defines.svh
// Assertion macros shared by the JSON lexer checker.
// No dependencies; included by the files that hold assertions.
`ifndef JSON_TOKEN_LEXER_UNIT_DEFINES_SVH
`define JSON_TOKEN_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define JTL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jtl check failed: ante |-> cons");

// Next-cycle implication, ignored while reset is high.
`define JTL_ASSERT_HOLD(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jtl check failed: ante |=> cons");

// Next-cycle implication that is checked during reset as well.
`define JTL_ASSERT_NEXT(label, clk, trig, cons) \
   label: assert property (@(posedge clk) (trig) |=> (cons)) \
      else $error("jtl check failed: trig |=> cons");

`endif

>>> rtl/core/jtl_pkg.sv
// Types, codes and character constants of the JSON token lexer.
// No dependencies; used by the lexer top level and its checker.
`default_nettype none

package jtl_pkg;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] char_value;
      logic       char_valid;
      logic       token_end;
      logic [1:0] constant_id;
      logic [2:0] error_code;
      logic       last_of_run;
   } result_type;

   localparam logic [3:0] KIND_BEGIN_OBJ = 4'd0;
   localparam logic [3:0] KIND_BEGIN_ARR = 4'd1;
   localparam logic [3:0] KIND_STRING    = 4'd2;
   localparam logic [3:0] KIND_COLON     = 4'd3;
   localparam logic [3:0] KIND_COMMA     = 4'd4;
   localparam logic [3:0] KIND_NUMBER    = 4'd5;
   localparam logic [3:0] KIND_CONSTANT  = 4'd6;
   localparam logic [3:0] KIND_END_OBJ   = 4'd7;
   localparam logic [3:0] KIND_END_ARR   = 4'd8;
   localparam logic [3:0] KIND_END       = 4'd9;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NEWLINE   = 3'd1;
   localparam logic [2:0] ERR_BAD_CONST = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
   localparam logic [2:0] ERR_MID_TOKEN = 3'd4;

   localparam logic [1:0] CONST_TRUE  = 2'd0;
   localparam logic [1:0] CONST_NULL  = 2'd1;
   localparam logic [1:0] CONST_FALSE = 2'd2;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_S  = 8'h73;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // Expected byte of a constant at a position; rows three and two both spell false.
   function automatic logic [7:0] const_char(input logic [1:0] row, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (row)
         CONST_TRUE: begin
            case (pos)
               3'd0: ch = CH_LOW_T;
               3'd1: ch = CH_LOW_R;
               3'd2: ch = CH_LOW_U;
               3'd3: ch = CH_LOW_E;
               default: ch = 8'h00;
            endcase
         end
         CONST_NULL: begin
            case (pos)
               3'd0: ch = CH_LOW_N;
               3'd1: ch = CH_LOW_U;
               3'd2: ch = CH_LOW_L;
               3'd3: ch = CH_LOW_L;
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               3'd0: ch = CH_LOW_F;
               3'd1: ch = CH_LOW_A;
               3'd2: ch = CH_LOW_L;
               3'd3: ch = CH_LOW_S;
               3'd4: ch = CH_LOW_E;
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

   function automatic result_type make_result(input logic [3:0] kind, input logic [7:0] ch,
                                              input logic cv, input logic te,
                                              input logic [1:0] cid, input logic [2:0] err);
      result_type r;
      r.kind        = kind;
      r.char_value  = cv ? ch : 8'h00;
      r.char_valid  = cv;
      r.token_end   = te;
      r.constant_id = cid;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/json_token_lexer_unit.sv
// JSON token lexer top level: byte decode, lexer state and result queue.
// Depends on jtl_pkg for result type, codes and character constants.
//
// Usage: one byte enters per req beat (req_data_byte, req_end_marker) when
// req_valid is high and req_stall is low. Each byte yields zero, one or two
// results on the rsp channel, each result one beat; rsp_last_of_run marks the
// last result of a byte. A byte is decoded in the cycle it is accepted and its
// results sit in a four-entry result queue and reach rsp from its registered
// entries. Throughput is one byte per cycle while req_stall is low; a byte
// with two results (a number closed by a token, or end of input after a
// number) fills two queue entries, each drained on its own rsp beat.
// req_stall is driven from the queue fill level alone and rises when fewer
// than two free entries remain, so a stalled rsp side backs up into req_stall
// without loss. Synchronous reset empties the queue and returns the lexer to
// the idle state between tokens with no error latched; the end marker does
// the same to the lexer state after giving its end result.
`default_nettype none

module json_token_lexer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_marker,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_kind,
   output logic [7:0]      rsp_char_value,
   output logic            rsp_char_valid,
   output logic            rsp_token_end,
   output logic [1:0]      rsp_constant_id,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last_of_run
);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_CONST  = 2'd3
   } mode_type;

   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CntWidth   = $clog2(QueueDepth + 1);

   mode_type                mode_ff, mode_in;
   logic [2:0]              pos_ff, pos_in;
   logic [1:0]              exp_ff, exp_in;
   logic                    match_ff, match_in;
   logic                    err_ff, err_in;

   jtl_pkg::result_type     queue_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]     count_ff, count_in;

   jtl_pkg::result_type     idle_res;
   logic                    idle_emit;
   mode_type                idle_mode;
   logic                    idle_err;
   logic                    idle_const;
   logic [1:0]              idle_exp;

   jtl_pkg::result_type     res0, res1, out0, out1;
   logic [1:0]              res_n;
   logic [1:0]              push_n;
   logic                    accept;
   logic                    pop;

   logic [7:0]              c;
   logic                    is_digit;
   logic [2:0]              const_len;
   logic [2:0]              pos_next;
   logic                    match_now;

   assign c        = req_data_byte;
   assign is_digit = (c >= jtl_pkg::CH_ZERO) && (c <= jtl_pkg::CH_NINE);

   always_comb begin
      idle_emit  = 1'b1;
      idle_mode  = MODE_IDLE;
      idle_err   = 1'b0;
      idle_const = 1'b0;
      idle_exp   = jtl_pkg::CONST_TRUE;
      idle_res   = jtl_pkg::make_result(jtl_pkg::KIND_END, c, 1'b1, 1'b1,
                                        jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
      case (c)
         jtl_pkg::CH_LBRACE: idle_res.kind = jtl_pkg::KIND_BEGIN_OBJ;
         jtl_pkg::CH_LBRACK: idle_res.kind = jtl_pkg::KIND_BEGIN_ARR;
         jtl_pkg::CH_COLON:  idle_res.kind = jtl_pkg::KIND_COLON;
         jtl_pkg::CH_COMMA:  idle_res.kind = jtl_pkg::KIND_COMMA;
         jtl_pkg::CH_RBRACE: idle_res.kind = jtl_pkg::KIND_END_OBJ;
         jtl_pkg::CH_RBRACK: idle_res.kind = jtl_pkg::KIND_END_ARR;
         jtl_pkg::CH_SPACE, jtl_pkg::CH_LF, jtl_pkg::CH_TAB, jtl_pkg::CH_CR: begin
            idle_emit = 1'b0;
         end
         jtl_pkg::CH_QUOTE: begin
            idle_emit = 1'b0;
            idle_mode = MODE_STRING;
         end
         jtl_pkg::CH_LOW_T, jtl_pkg::CH_LOW_N, jtl_pkg::CH_LOW_F: begin
            idle_emit  = 1'b0;
            idle_mode  = MODE_CONST;
            idle_const = 1'b1;
            idle_exp   = (c == jtl_pkg::CH_LOW_T) ? jtl_pkg::CONST_TRUE :
                         (c == jtl_pkg::CH_LOW_N) ? jtl_pkg::CONST_NULL :
                                                    jtl_pkg::CONST_FALSE;
         end
         default: begin
            if (is_digit || c == jtl_pkg::CH_DOT) begin
               idle_mode = MODE_NUMBER;
               idle_res  = jtl_pkg::make_result(jtl_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
                                                jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
            end else begin
               idle_err = 1'b1;
               idle_res = jtl_pkg::make_result(jtl_pkg::KIND_END, c, 1'b0, 1'b1,
                                               jtl_pkg::CONST_TRUE, jtl_pkg::ERR_UNKNOWN);
            end
         end
      endcase
   end

   assign const_len = (exp_ff >= jtl_pkg::CONST_FALSE) ? 3'd5 : 3'd4;
   assign pos_next  = pos_ff + 3'd1;
   assign match_now = match_ff && (pos_ff < const_len) &&
                      (c == jtl_pkg::const_char(exp_ff, pos_ff));

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      exp_in   = exp_ff;
      match_in = match_ff;
      err_in   = err_ff;
      res0     = jtl_pkg::make_result(jtl_pkg::KIND_END, 8'h00, 1'b0, 1'b1,
                                      jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
      res1     = res0;
      res_n    = 2'd0;
      if (req_end_marker) begin
         res_n = 2'd1;
         case (mode_ff)
            MODE_NUMBER: begin
               res0  = jtl_pkg::make_result(jtl_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                            jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
               res_n = 2'd2;
            end
            MODE_STRING, MODE_CONST: begin
               res0.error_code = jtl_pkg::ERR_MID_TOKEN;
            end
            default: begin
            end
         endcase
         mode_in  = MODE_IDLE;
         pos_in   = 3'd0;
         exp_in   = jtl_pkg::CONST_TRUE;
         match_in = 1'b1;
         err_in   = 1'b0;
      end else if (!err_ff) begin
         case (mode_ff)
            MODE_STRING: begin
               res_n = 2'd1;
               if (c == jtl_pkg::CH_QUOTE) begin
                  res0    = jtl_pkg::make_result(jtl_pkg::KIND_STRING, c, 1'b0, 1'b1,
                                                 jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
                  mode_in = MODE_IDLE;
               end else if (c == jtl_pkg::CH_LF) begin
                  res0.error_code = jtl_pkg::ERR_NEWLINE;
                  err_in          = 1'b1;
                  mode_in         = MODE_IDLE;
               end else begin
                  res0 = jtl_pkg::make_result(jtl_pkg::KIND_STRING, c, 1'b1, 1'b0,
                                              jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
               end
            end
            MODE_NUMBER: begin
               res_n = 2'd1;
               if (is_digit || c == jtl_pkg::CH_DOT || c == jtl_pkg::CH_LOW_E ||
                   c == jtl_pkg::CH_MINUS) begin
                  res0 = jtl_pkg::make_result(jtl_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
                                              jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
               end else begin
                  res0    = jtl_pkg::make_result(jtl_pkg::KIND_NUMBER, c, 1'b0, 1'b1,
                                                 jtl_pkg::CONST_TRUE, jtl_pkg::ERR_NONE);
                  mode_in = idle_mode;
                  err_in  = idle_err;
                  if (idle_const) begin
                     exp_in   = idle_exp;
                     pos_in   = 3'd1;
                     match_in = 1'b1;
                  end
                  if (idle_emit) begin
                     res1  = idle_res;
                     res_n = 2'd2;
                  end
               end
            end
            MODE_CONST: begin
               if (pos_next >= const_len) begin
                  res_n   = 2'd1;
                  mode_in = MODE_IDLE;
                  if (match_now) begin
                     res0 = jtl_pkg::make_result(jtl_pkg::KIND_CONSTANT, c, 1'b0, 1'b1,
                                                 (exp_ff == 2'd3) ? jtl_pkg::CONST_FALSE
                                                                  : exp_ff,
                                                 jtl_pkg::ERR_NONE);
                  end else begin
                     res0.error_code = jtl_pkg::ERR_BAD_CONST;
                     err_in          = 1'b1;
                  end
                  pos_in   = 3'd0;
                  match_in = 1'b1;
               end else begin
                  pos_in   = pos_next;
                  match_in = match_now;
               end
            end
            default: begin
               mode_in = idle_mode;
               err_in  = idle_err;
               if (idle_const) begin
                  exp_in   = idle_exp;
                  pos_in   = 3'd1;
                  match_in = 1'b1;
               end
               if (idle_emit) begin
                  res0  = idle_res;
                  res_n = 2'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      out0 = res0;
      out1 = res1;
      out0.last_of_run = (res_n == 2'd1);
      out1.last_of_run = 1'b1;
   end

   assign req_stall = (count_ff > CntWidth'(QueueDepth - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = accept ? res_n : 2'd0;

   assign wr_ptr_in = wr_ptr_ff + PtrWidth'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + CntWidth'(push_n) - CntWidth'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= out0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrWidth'(1)] <= out1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= 3'd0;
         exp_ff    <= jtl_pkg::CONST_TRUE;
         match_ff  <= 1'b1;
         err_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            exp_ff   <= exp_in;
            match_ff <= match_in;
            err_ff   <= err_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_kind        = queue_ff[rd_ptr_ff].kind;
   assign rsp_char_value  = queue_ff[rd_ptr_ff].char_value;
   assign rsp_char_valid  = queue_ff[rd_ptr_ff].char_valid;
   assign rsp_token_end   = queue_ff[rd_ptr_ff].token_end;
   assign rsp_constant_id = queue_ff[rd_ptr_ff].constant_id;
   assign rsp_error_code  = queue_ff[rd_ptr_ff].error_code;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;

endmodule

`default_nettype wire

>>> rtl/core/jtl_checker.sv
// Port-level checks of the JSON lexer result channel, bound to the top level.
// Depends on jtl_pkg and json_token_lexer_unit_defines.svh.
`default_nettype none

`include "json_token_lexer_unit_defines.svh"

module jtl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_kind,
   input wire logic [7:0] rsp_char_value,
   input wire logic       rsp_char_valid,
   input wire logic       rsp_token_end,
   input wire logic [2:0] rsp_error_code,
   input wire logic       rsp_last_of_run
);

   `JTL_ASSERT_NEXT(a_reset_empties, clock, reset, !rsp_valid)

   `JTL_ASSERT_HOLD(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_char_value) && $stable(rsp_last_of_run))

   `JTL_ASSERT_IMPLY(a_end_closes_run, clock, reset, rsp_valid && rsp_kind == jtl_pkg::KIND_END, rsp_token_end && rsp_last_of_run && !rsp_char_valid)

   `JTL_ASSERT_IMPLY(a_error_is_end, clock, reset, rsp_valid && rsp_error_code != jtl_pkg::ERR_NONE, rsp_kind == jtl_pkg::KIND_END)

   `JTL_ASSERT_IMPLY(a_char_zeroed, clock, reset, rsp_valid && !rsp_char_valid, rsp_char_value == 8'h00)

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_char_value  (rsp_char_value),
   .rsp_char_valid  (rsp_char_valid),
   .rsp_token_end   (rsp_token_end),
   .rsp_error_code  (rsp_error_code),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
